// ===== src/c2pa_pkg.sv =====
`default_nettype none
package c2pa_pkg;

  // Defaults for the top-level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 24;

  // Fraction bits added below the input LSB during the iterations
  localparam int GUARD_BITS = 8;

  // Result field widths
  localparam int RADIUS_W    = 24;
  localparam int ANGLE_W     = 16;
  localparam int PHASE_W     = 17;
  localparam int TURN_W      = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam logic [TURN_W-1:0]   HALF_TURN  = 32'h8000_0000;
  localparam logic [TURN_W-1:0]   ANGLE_RND  = 32'h0000_8000;
  localparam logic [31:0]         INV_GAIN   = 32'h9B74_EDA8;

  // Exact axis angles in 1/65536 turn
  localparam logic [ANGLE_W-1:0] ANG_ZERO    = 16'd0;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER = 16'd16384;
  localparam logic [ANGLE_W-1:0] ANG_HALF    = 16'd32768;
  localparam logic [ANGLE_W-1:0] ANG_3QUART  = 16'd49152;

  // atan(2^-i) in 1/2^32 turn
  localparam int ATAN_LEN = 24;
  localparam logic [TURN_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Zero and sign facts of one input vector, taken before the fold
  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_zero;
    logic y_neg;
  } axis_t;

  typedef struct packed {
    axis_t pos;
    axis_t vel;
  } axis_pair_t;

endpackage
`default_nettype wire

// ===== src/cartesian_to_polar_angle.sv =====
// Path: stage 0, the CORDIC_STEPS iteration stages, then the product and output stages.
// Throughput: one beat per cycle unless stalled; a stalled output holds its beat
//   while empty stages upstream fill; bubbles collapse, no beat is dropped or repeated.
// Reset: rst (synchronous, active high) clears every stage valid bit; payload
//   registers are not reset.
`default_nettype none
module cartesian_to_polar_angle
  import c2pa_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y (COORD_WIDTH each), zero pad to whole bytes
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // radius (24), position_angle (16), orbit_phase (17), zero pad to 64
  output logic [OUT_TDATA_W-1:0]                   m_axis_tdata
);

  localparam int CW         = COORD_WIDTH;
  // Working width: sign, half-turn fold of the most negative value, guard bits and
  // CORDIC gain growth (below 2.33 times the folded magnitude)
  localparam int XW         = COORD_WIDTH + GUARD_BITS + 3;
  // Stage map: 0 fold/scale, 1..CORDIC_STEPS iterations, then product, then output
  localparam int MUL_ST     = CORDIC_STEPS + 1;
  localparam int OUT_ST     = CORDIC_STEPS + 2;
  localparam int NST        = CORDIC_STEPS + 3;
  localparam int PAD_W      = OUT_TDATA_W - RADIUS_W - ANGLE_W - PHASE_W;

  // Per-stage valid and advance. A stage advances when it is empty or its
  // successor advances, so bubbles collapse behind a stalled output.
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  assign adv[NST-1] = !vld[NST-1] || m_axis_tready;
  for (genvar k = 0; k < NST-1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign s_axis_tready = adv[0];

  // ---------------------------------------------------------------------------
  // Stage 0: unpack, build the orbit vector (vel_y, -vel_x), fold the left half
  // plane by a half turn, scale up by the guard bits, capture axis facts.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;

  assign in_pos_x = s_axis_tdata[0*CW +: CW];
  assign in_pos_y = s_axis_tdata[1*CW +: CW];
  assign in_vel_x = s_axis_tdata[2*CW +: CW];
  assign in_vel_y = s_axis_tdata[3*CW +: CW];

  logic signed [XW-1:0]     pa_x, pa_y, va_x, va_y;
  logic signed [XW-1:0]     pos_x0_next, pos_y0_next, vel_x0_next, vel_y0_next;
  logic        [TURN_W-1:0] pos_z0_next, vel_z0_next;
  axis_pair_t               axis0_next;

  always_comb begin
    pa_x = XW'(in_pos_x);
    pa_y = XW'(in_pos_y);
    va_x = XW'(in_vel_y);
    va_y = -XW'(in_vel_x);

    axis0_next.pos.x_zero = (pa_x == '0);
    axis0_next.pos.x_neg  = pa_x[XW-1];
    axis0_next.pos.y_zero = (pa_y == '0);
    axis0_next.pos.y_neg  = pa_y[XW-1];
    axis0_next.vel.x_zero = (va_x == '0);
    axis0_next.vel.x_neg  = va_x[XW-1];
    axis0_next.vel.y_zero = (va_y == '0);
    axis0_next.vel.y_neg  = va_y[XW-1];

    // Turn left-half-plane points by a half turn so the iterations converge
    if (pa_x[XW-1]) begin
      pos_x0_next = (-pa_x) <<< GUARD_BITS;
      pos_y0_next = (-pa_y) <<< GUARD_BITS;
      pos_z0_next = HALF_TURN;
    end else begin
      pos_x0_next = pa_x <<< GUARD_BITS;
      pos_y0_next = pa_y <<< GUARD_BITS;
      pos_z0_next = '0;
    end
    if (va_x[XW-1]) begin
      vel_x0_next = (-va_x) <<< GUARD_BITS;
      vel_y0_next = (-va_y) <<< GUARD_BITS;
      vel_z0_next = HALF_TURN;
    end else begin
      vel_x0_next = va_x <<< GUARD_BITS;
      vel_y0_next = va_y <<< GUARD_BITS;
      vel_z0_next = '0;
    end
  end

  logic signed [XW-1:0]     pos_x [0:CORDIC_STEPS];
  logic signed [XW-1:0]     pos_y [0:CORDIC_STEPS];
  logic        [TURN_W-1:0] pos_z [0:CORDIC_STEPS];
  logic signed [XW-1:0]     vel_x [0:CORDIC_STEPS];
  logic signed [XW-1:0]     vel_y [0:CORDIC_STEPS];
  logic        [TURN_W-1:0] vel_z [0:CORDIC_STEPS];
  axis_pair_t               axis  [0:CORDIC_STEPS];

  logic                     vld_in;
  logic signed [XW-1:0]     pos_x0, pos_y0, vel_x0, vel_y0;
  logic        [TURN_W-1:0] pos_z0, vel_z0;
  axis_pair_t               axis0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_in <= 1'b0;
    end else if (adv[0]) begin
      vld_in <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pos_x0 <= pos_x0_next;
      pos_y0 <= pos_y0_next;
      pos_z0 <= pos_z0_next;
      vel_x0 <= vel_x0_next;
      vel_y0 <= vel_y0_next;
      vel_z0 <= vel_z0_next;
      axis0  <= axis0_next;
    end
  end

  assign vld[0]   = vld_in;
  assign pos_x[0] = pos_x0;
  assign pos_y[0] = pos_y0;
  assign pos_z[0] = pos_z0;
  assign vel_x[0] = vel_x0;
  assign vel_y[0] = vel_y0;
  assign vel_z[0] = vel_z0;
  assign axis[0]  = axis0;

  // ---------------------------------------------------------------------------
  // Stages 1..CORDIC_STEPS: one micro-rotation each, both vectors side by side.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    c2pa_stage #(
      .STEP (i),
      .XW   (XW)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv[i+1]),
      .in_valid  (vld[i]),
      .in_pos_x  (pos_x[i]),
      .in_pos_y  (pos_y[i]),
      .in_pos_z  (pos_z[i]),
      .in_vel_x  (vel_x[i]),
      .in_vel_y  (vel_y[i]),
      .in_vel_z  (vel_z[i]),
      .in_axis   (axis[i]),
      .out_valid (vld[i+1]),
      .out_pos_x (pos_x[i+1]),
      .out_pos_y (pos_y[i+1]),
      .out_pos_z (pos_z[i+1]),
      .out_vel_x (vel_x[i+1]),
      .out_vel_y (vel_y[i+1]),
      .out_vel_z (vel_z[i+1]),
      .out_axis  (axis[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Product stage: gain correction as two 32-bit partial products (high and low
  // word of the magnitude), rounding of both angles with the axis repair.
  // ---------------------------------------------------------------------------
  function automatic logic [ANGLE_W-1:0] angle_round(input logic [TURN_W-1:0] z,
                                                     input axis_t ax);
    logic [TURN_W-1:0] zr;
    zr = z + ANGLE_RND;
    if (ax.y_zero) begin
      angle_round = ax.x_neg ? ANG_HALF : ANG_ZERO;
    end else if (ax.x_zero) begin
      angle_round = ax.y_neg ? ANG_3QUART : ANG_QUARTER;
    end else begin
      angle_round = zr[TURN_W-1 -: ANGLE_W];
    end
  endfunction

  logic signed [XW-1:0] mag_x;
  logic        [63:0]   mag;
  logic        [63:0]   prod_hi_next, prod_lo_next;
  logic        [63:0]   prod_hi;
  logic        [32:0]   prod_lo;
  logic [ANGLE_W-1:0]   pos_ang, vel_ang;
  logic                 vld_mul;

  always_comb begin
    mag_x = pos_x[CORDIC_STEPS];
    // Clamp a negative residue to zero
    mag   = mag_x[XW-1] ? 64'd0 : 64'($unsigned(mag_x));
    prod_hi_next = mag[63:32] * INV_GAIN;
    prod_lo_next = mag[31:0] * INV_GAIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_mul <= 1'b0;
    end else if (adv[MUL_ST]) begin
      vld_mul <= vld[CORDIC_STEPS];
    end
  end

  assign vld[MUL_ST] = vld_mul;

  always_ff @(posedge clk) begin
    if (adv[MUL_ST]) begin
      prod_hi <= prod_hi_next;
      // Fold the half-LSB rounding constant in here to keep the output adder short
      prod_lo <= 33'(prod_lo_next[63:32]) + 33'(1 << (GUARD_BITS - 1));
      pos_ang <= angle_round(pos_z[CORDIC_STEPS], axis[CORDIC_STEPS].pos);
      vel_ang <= angle_round(vel_z[CORDIC_STEPS], axis[CORDIC_STEPS].vel);
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: sum, drop guard bits, saturate; fold the orbit phase so the
  // last quarter turn reads as negative.
  // ---------------------------------------------------------------------------
  logic [63:0]           rad_sum, rad_shift;
  logic [RADIUS_W-1:0]   radius_next;
  logic [PHASE_W-1:0]    phase_next;
  logic [RADIUS_W-1:0]   radius;
  logic [ANGLE_W-1:0]    position_angle;
  logic [PHASE_W-1:0]    orbit_phase;
  logic                  vld_out;

  always_comb begin
    rad_sum   = prod_hi + 64'(prod_lo);
    rad_shift = rad_sum >> GUARD_BITS;
    radius_next = (|rad_shift[63:RADIUS_W]) ? RADIUS_MAX : rad_shift[RADIUS_W-1:0];
    // Angles at or past three quarters of a turn wrap to negative
    phase_next = {(vel_ang[ANGLE_W-1] & vel_ang[ANGLE_W-2]), vel_ang};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv[OUT_ST]) begin
      vld_out <= vld[MUL_ST];
    end
  end

  assign vld[OUT_ST] = vld_out;

  always_ff @(posedge clk) begin
    if (adv[OUT_ST]) begin
      radius         <= radius_next;
      position_angle <= pos_ang;
      orbit_phase    <= phase_next;
    end
  end

  assign m_axis_tvalid = vld_out;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, orbit_phase, position_angle, radius};

endmodule
`default_nettype wire

// ===== src/c2pa_stage.sv =====
`default_nettype none
module c2pa_stage
  import c2pa_pkg::*;
#(
  parameter int STEP = 0,
  parameter int XW   = COORD_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [XW-1:0]     in_pos_x,
  input  logic signed [XW-1:0]     in_pos_y,
  input  logic        [TURN_W-1:0] in_pos_z,
  input  logic signed [XW-1:0]     in_vel_x,
  input  logic signed [XW-1:0]     in_vel_y,
  input  logic        [TURN_W-1:0] in_vel_z,
  input  axis_pair_t               in_axis,
  output logic                     out_valid,
  output logic signed [XW-1:0]     out_pos_x,
  output logic signed [XW-1:0]     out_pos_y,
  output logic        [TURN_W-1:0] out_pos_z,
  output logic signed [XW-1:0]     out_vel_x,
  output logic signed [XW-1:0]     out_vel_y,
  output logic        [TURN_W-1:0] out_vel_z,
  output axis_pair_t               out_axis
);

  localparam logic [TURN_W-1:0] ATAN_STEP = ATAN_TURNS[STEP];

  logic signed [XW-1:0]     pos_x_next, pos_y_next, vel_x_next, vel_y_next;
  logic        [TURN_W-1:0] pos_z_next, vel_z_next;

  // One vectoring micro-rotation per vector: drive y toward zero
  always_comb begin
    if (in_pos_y[XW-1]) begin
      pos_x_next = in_pos_x - (in_pos_y >>> STEP);
      pos_y_next = in_pos_y + (in_pos_x >>> STEP);
      pos_z_next = in_pos_z - ATAN_STEP;
    end else begin
      pos_x_next = in_pos_x + (in_pos_y >>> STEP);
      pos_y_next = in_pos_y - (in_pos_x >>> STEP);
      pos_z_next = in_pos_z + ATAN_STEP;
    end
    if (in_vel_y[XW-1]) begin
      vel_x_next = in_vel_x - (in_vel_y >>> STEP);
      vel_y_next = in_vel_y + (in_vel_x >>> STEP);
      vel_z_next = in_vel_z - ATAN_STEP;
    end else begin
      vel_x_next = in_vel_x + (in_vel_y >>> STEP);
      vel_y_next = in_vel_y - (in_vel_x >>> STEP);
      vel_z_next = in_vel_z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x <= pos_x_next;
      out_pos_y <= pos_y_next;
      out_pos_z <= pos_z_next;
      out_vel_x <= vel_x_next;
      out_vel_y <= vel_y_next;
      out_vel_z <= vel_z_next;
      out_axis  <= in_axis;
    end
  end

endmodule
`default_nettype wire

// ===== src/c2pa_checker.sv =====
`default_nettype none
module c2pa_checker
  import c2pa_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int PH_LO = RADIUS_W + ANGLE_W;
  localparam int PH_HI = PH_LO + PHASE_W - 1;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat present right after reset");

  // A beat refused downstream holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // An empty output stage means every stage can move, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with an empty output stage");

  // Orbit phase stays within minus a quarter to three quarters of a turn
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (!m_axis_tdata[PH_HI] && (m_axis_tdata[PH_HI-1:PH_HI-2] != 2'b11)) ||
      (m_axis_tdata[PH_HI] && (m_axis_tdata[PH_HI-1:PH_HI-2] == 2'b11)))
    else $error("orbit phase out of range");

endmodule

bind cartesian_to_polar_angle c2pa_checker u_c2pa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/tb_cartesian_to_polar_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_cartesian_to_polar_angle;
  import c2pa_pkg::*;

  localparam int STEPS      = CORDIC_STEPS_DEF;
  localparam int COORD_W    = COORD_WIDTH_DEF;
  localparam int IN_W       = ((4*COORD_W+7)/8)*8;
  localparam int LATENCY    = STEPS + 3;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 2000;

  // Coordinate extremes and the folded three-quarter angle (-1/4 turn)
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [PHASE_W-1:0] PHASE_NEG_QUARTER = 17'h1C000;

  typedef struct {
    logic [RADIUS_W-1:0] radius;
    logic [ANGLE_W-1:0]  pos_angle;
    logic [PHASE_W-1:0]  phase;
  } polar_t;

  typedef struct {
    logic signed [COORD_W-1:0] px, py, vx, vy;
    bit                        ang_typed;
    bit                        rad_typed;
    polar_t                    typed;
  } sample_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  polar_t      pending_polar [$];
  sample_row_t sample_table [$];
  polar_t      oldest;
  int          err_count = 0;
  int          checked_count = 0;
  int          axis_samples = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  wire in_beat  = s_axis_tvalid && s_axis_tready;
  wire out_beat = m_axis_tvalid && m_axis_tready;

  cartesian_to_polar_angle #(
    .CORDIC_STEPS(STEPS),
    .COORD_WIDTH (COORD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Vectoring CORDIC on (x, y): returns the full-turn angle, exact on the axes,
  // and hands back the gain-scaled magnitude with guard bits.
  function automatic logic [ANGLE_W-1:0] turn_angle(input longint x, input longint y,
                                                    output longint unsigned mag);
    longint      cx, cy, dx, dy;
    logic [TURN_W-1:0] z;
    logic [TURN_W-1:0] zr;
    cx = x;
    cy = y;
    z  = '0;
    // Fold the left half plane onto the right one
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z  = HALF_TURN;
    end
    cx = cx * (longint'(1) << GUARD_BITS);
    cy = cy * (longint'(1) << GUARD_BITS);
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy < 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - ATAN_TURNS[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + ATAN_TURNS[i];
      end
    end
    mag = (cx < 0) ? 64'd0 : longint'(cx);
    zr  = z + ANGLE_RND;
    if (y == 0)
      return (x < 0) ? ANG_HALF : ANG_ZERO;
    if (x == 0)
      return (y > 0) ? ANG_QUARTER : ANG_3QUART;
    return zr[TURN_W-1:TURN_W-ANGLE_W];
  endfunction

  // Undo the CORDIC gain, drop the guard bits with rounding, saturate
  function automatic logic [RADIUS_W-1:0] scale_radius(input longint unsigned m);
    longint unsigned hi, lo, t, r, gain;
    gain = {32'd0, INV_GAIN};
    hi   = m >> 32;
    lo   = m & 64'hFFFF_FFFF;
    t    = hi * gain + ((lo * gain) >> 32);
    r    = (t + (64'd1 << (GUARD_BITS-1))) >> GUARD_BITS;
    return (r > RADIUS_MAX) ? RADIUS_MAX : r[RADIUS_W-1:0];
  endfunction

  function automatic polar_t predict_polar(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py,
                                           input logic signed [COORD_W-1:0] vx,
                                           input logic signed [COORD_W-1:0] vy);
    polar_t            res;
    longint unsigned   mag, unused_mag;
    logic [ANGLE_W-1:0] orbit;
    res.pos_angle = turn_angle(longint'(px), longint'(py), mag);
    res.radius    = scale_radius(mag);
    // Orbit phase is the angle of (vy, -vx), folded to start at -1/4 turn
    orbit = turn_angle(longint'(vy), -longint'(vx), unused_mag);
    if (orbit >= ANG_3QUART)
      res.phase = {1'b0, orbit} - 17'h10000;
    else
      res.phase = {1'b0, orbit};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
             what, checked_count, got, want);
    err_count++;
  endtask

  task automatic add_row(input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
                         input logic signed [COORD_W-1:0] vx, input logic signed [COORD_W-1:0] vy,
                         input bit ang_typed, input bit rad_typed,
                         input logic [ANGLE_W-1:0] pa, input logic [PHASE_W-1:0] ph);
    sample_row_t r;
    r.px = px;
    r.py = py;
    r.vx = vx;
    r.vy = vy;
    r.ang_typed       = ang_typed;
    r.rad_typed       = rad_typed;
    r.typed.radius    = '0;
    r.typed.pos_angle = pa;
    r.typed.phase     = ph;
    sample_table.insert(sample_table.size(), r);
  endtask

  // Mostly full range, with a heavy share of small values, zeros and extremes
  // so the axis repairs and the sign folds are hit often.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned pick;
    logic signed [COORD_W-1:0] v;
    pick = $urandom_range(99);
    v    = COORD_W'($urandom);
    if (pick < 55)
      return v;
    if (pick < 75)
      return v >>> $urandom_range(COORD_W-1);
    if (pick < 90)
      return '0;
    case ($urandom_range(4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return -1;
      3:       return 1;
      default: return C_MIN + COORD_W'(1);
    endcase
  endfunction

  // Offer one beat, with a random gap in front of it, and queue its result once taken
  task automatic send_sample(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] vx,
                             input logic signed [COORD_W-1:0] vy,
                             input polar_t want);
    while (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({vy, vx, py, px});
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    if (px == 0 || py == 0)
      axis_samples++;
    pending_polar.insert(pending_polar.size(), want);
  endtask

  // Receiver: stall at random, except during the calm stretch
  always @(posedge clk) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  // Compare every output beat with the oldest queued result
  always @(posedge clk) begin
    if (!rst && out_beat) begin
      if (pending_polar.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 0);
      end else begin
        oldest = pending_polar.pop_front();
        if (m_axis_tdata[23:0] !== oldest.radius)
          report_mismatch("radius", m_axis_tdata[23:0], oldest.radius);
        if (m_axis_tdata[39:24] !== oldest.pos_angle)
          report_mismatch("position_angle", m_axis_tdata[39:24], oldest.pos_angle);
        if (m_axis_tdata[56:40] !== oldest.phase)
          report_mismatch("orbit_phase", m_axis_tdata[56:40], oldest.phase);
        if (m_axis_tdata[63:57] !== '0)
          report_mismatch("pad", m_axis_tdata[63:57], 0);
        checked_count++;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || in_beat || out_beat)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    polar_t want;
    logic signed [COORD_W-1:0] px, py, vx, vy;

    // Axis points and the origin: angles are exact, so type them in
    add_row(0, 0, 0, 0, 1, 1, ANG_ZERO, {1'b0, ANG_ZERO});
    add_row(C_MAX, 0, 0, C_MAX, 1, 0, ANG_ZERO, {1'b0, ANG_ZERO});
    add_row(C_MIN, 0, 0, C_MIN, 1, 0, ANG_HALF, {1'b0, ANG_HALF});
    add_row(0, C_MAX, C_MIN, 0, 1, 0, ANG_QUARTER, {1'b0, ANG_QUARTER});
    add_row(0, C_MIN, C_MAX, 0, 1, 0, ANG_3QUART, PHASE_NEG_QUARTER);
    add_row(1, 0, 0, 1, 1, 0, ANG_ZERO, {1'b0, ANG_ZERO});
    add_row(-1, 0, 0, -1, 1, 0, ANG_HALF, {1'b0, ANG_HALF});
    add_row(0, 1, -1, 0, 1, 0, ANG_QUARTER, {1'b0, ANG_QUARTER});
    add_row(0, -1, 1, 0, 1, 0, ANG_3QUART, PHASE_NEG_QUARTER);
    // Corners, near-axis wraps and fold boundaries go through the predictor
    add_row(C_MAX, C_MAX, C_MAX, C_MAX, 0, 0, '0, '0);
    add_row(C_MIN, C_MIN, C_MIN, C_MIN, 0, 0, '0, '0);
    add_row(C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, '0, '0);
    add_row(C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, '0, '0);
    add_row(C_MAX, -1, 1, C_MAX, 0, 0, '0, '0);
    add_row(C_MIN, -1, -1, C_MIN, 0, 0, '0, '0);
    add_row(C_MIN, 1, 1, C_MIN, 0, 0, '0, '0);
    add_row(1, C_MIN, C_MAX, 1, 0, 0, '0, '0);
    add_row(-1, C_MIN, C_MAX, -1, 0, 0, '0, '0);
    add_row(-1, -1, 1, -1, 0, 0, '0, '0);
    add_row(12345, -67890, -424242, 777777, 0, 0, '0, '0);
    add_row(0, 0, C_MAX, C_MAX, 0, 0, '0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (sample_table[k]) begin
      want = predict_polar(sample_table[k].px, sample_table[k].py,
                           sample_table[k].vx, sample_table[k].vy);
      if (sample_table[k].ang_typed) begin
        want.pos_angle = sample_table[k].typed.pos_angle;
        want.phase     = sample_table[k].typed.phase;
      end
      if (sample_table[k].rad_typed)
        want.radius = sample_table[k].typed.radius;
      send_sample(sample_table[k].px, sample_table[k].py,
                  sample_table[k].vx, sample_table[k].vy, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Drain the pipe once mid-run, then run a stretch with no stalls at all
      if (n == 1000) begin
        s_axis_tvalid <= 1'b0;
        while (pending_polar.size() != 0)
          @(posedge clk);
      end
      calm = (n >= 1200 && n < 1500);
      px = rand_coord();
      py = rand_coord();
      vx = rand_coord();
      vy = rand_coord();
      send_sample(px, py, vx, vy, predict_polar(px, py, vx, vy));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_polar.size() != 0)
      @(posedge clk);
    // Hold a little past the pipe depth to catch stray beats
    repeat (LATENCY + 10) @(posedge clk);

    $display("Covered %0d directed and %0d random samples, %0d results checked.",
             sample_table.size(), RANDOM_ITEMS, checked_count);
    $display("Samples with a position on an axis: %0d; mismatches: %0d.",
             axis_samples, err_count);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
